// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is released.
`define AST_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lre checker: property violated");

// Property checked at every edge, reset included.
`define AST_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lre checker: property violated");

`endif

// ===== rtl/core/lre_pkg.sv =====
package lre_pkg;

    localparam int CMD_BITS        = 2;
    localparam int IDX_BITS        = 16;
    localparam int PIX_FIELD_BITS  = 16;
    localparam int SIZE_BITS       = 9;
    localparam int STEP_BITS       = 24;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 24;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CR_LINE_WIDTH    = 2'd0,
        CR_LINE_COUNT    = 2'd1,
        CR_STEP_MAG      = 2'd2,
        CR_STEP_NEGATIVE = 2'd3
    } t_cfg_reg;

    // Program steps of the run sequencer.
    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_RD_WAIT    = 4'd1,
        ST_SETUP_SIZE = 4'd2,
        ST_SETUP_LAST = 4'd3,
        ST_PASS_INIT  = 4'd4,
        ST_LINE_INIT  = 4'd5,
        ST_LINE_FIRST = 4'd6,
        ST_PIX_READ   = 4'd7,
        ST_PIX_UPDATE = 4'd8,
        ST_LINE_END   = 4'd9,
        ST_PASS_END   = 4'd10,
        ST_RUN_DONE   = 4'd11
    } t_step;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_JUMP,
        SQ_BRANCH,
        SQ_DISPATCH
    } t_seq;

    typedef enum logic [1:0] {
        CD_SKIP_PASS,
        CD_MORE_PIX,
        CD_MORE_LINES,
        CD_MORE_PASSES
    } t_cond;

    typedef enum logic [3:0] {
        DO_NONE,
        DO_SIZE,
        DO_LAST,
        DO_PASS,
        DO_LINE,
        DO_FIRST,
        DO_ADV,
        DO_UPD,
        DO_LEND,
        DO_PEND
    } t_dop;

    typedef enum logic [1:0] {
        OO_NONE,
        OO_READ,
        OO_RUN
    } t_oop;

    typedef enum logic [1:0] {
        PS_ROW_FWD = 2'd0,
        PS_ROW_REV = 2'd1,
        PS_COL_FWD = 2'd2,
        PS_COL_REV = 2'd3
    } t_pass;

    typedef struct packed {
        t_seq  seq;
        t_cond cond;
        t_step target;
        t_dop  dop;
        t_oop  oop;
        logic  host;
    } t_uword;

    typedef struct packed {
        logic skip_pass;
        logic more_pix;
        logic more_lines;
        logic more_passes;
    } t_loop_flags;

    typedef struct packed {
        logic accept;
        t_cmd cmd;
        logic step_zero;
    } t_host_req;

    // Control store: one word per step.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{seq: SQ_NEXT, cond: CD_MORE_PIX, target: ST_IDLE,
              dop: DO_NONE, oop: OO_NONE, host: 1'b0};
        unique case (s)
            ST_IDLE: begin
                w.seq  = SQ_DISPATCH;
                w.host = 1'b1;
            end
            ST_RD_WAIT: begin
                w.seq = SQ_JUMP;
                w.oop = OO_READ;
            end
            ST_SETUP_SIZE: w.dop = DO_SIZE;
            ST_SETUP_LAST: w.dop = DO_LAST;
            ST_PASS_INIT: begin
                w.seq    = SQ_BRANCH;
                w.cond   = CD_SKIP_PASS;
                w.target = ST_PASS_END;
                w.dop    = DO_PASS;
            end
            ST_LINE_INIT:  w.dop = DO_LINE;
            ST_LINE_FIRST: w.dop = DO_FIRST;
            ST_PIX_READ:   w.dop = DO_ADV;
            ST_PIX_UPDATE: begin
                w.seq    = SQ_BRANCH;
                w.cond   = CD_MORE_PIX;
                w.target = ST_PIX_READ;
                w.dop    = DO_UPD;
            end
            ST_LINE_END: begin
                w.seq    = SQ_BRANCH;
                w.cond   = CD_MORE_LINES;
                w.target = ST_LINE_INIT;
                w.dop    = DO_LEND;
            end
            ST_PASS_END: begin
                w.seq    = SQ_BRANCH;
                w.cond   = CD_MORE_PASSES;
                w.target = ST_PASS_INIT;
                w.dop    = DO_PEND;
            end
            ST_RUN_DONE: begin
                w.seq = SQ_JUMP;
                w.oop = OO_RUN;
            end
            default: w.seq = SQ_JUMP;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/lre_in_if.sv =====
interface lre_in_if import lre_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_BITS-1:0]       cmd;
    logic [IDX_BITS-1:0]       pixel_index;
    logic [PIX_FIELD_BITS-1:0] pixel_value;

    modport source (output valid, output cmd, output pixel_index, output pixel_value,
                    input ready);
    modport sink   (input valid, input cmd, input pixel_index, input pixel_value,
                    output ready);
endinterface

// ===== rtl/core/lre_out_if.sv =====
interface lre_out_if import lre_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [PIX_FIELD_BITS-1:0] read_value;
    logic                      status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

// ===== rtl/core/lre_ram.sv =====
module lre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lre_seq.sv =====
module lre_seq import lre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_loop_flags i_loop,
    input  t_host_req   i_host,
    output t_uword      o_uword
);

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   cond_true;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uw = ucode(r_step);
        unique case (uw.cond)
            CD_SKIP_PASS:   cond_true = i_loop.skip_pass;
            CD_MORE_PIX:    cond_true = i_loop.more_pix;
            CD_MORE_LINES:  cond_true = i_loop.more_lines;
            CD_MORE_PASSES: cond_true = i_loop.more_passes;
            default:        cond_true = 1'b0;
        endcase

        n_step = r_step;
        unique case (uw.seq)
            SQ_NEXT:   n_step = t_step'(4'(r_step) + 4'd1);
            SQ_JUMP:   n_step = uw.target;
            SQ_BRANCH: n_step = cond_true ? uw.target : t_step'(4'(r_step) + 4'd1);
            SQ_DISPATCH: begin
                if (i_host.accept) begin
                    if (i_host.cmd == CMD_READ) begin
                        n_step = ST_RD_WAIT;
                    end else if (i_host.cmd == CMD_RUN && !i_host.step_zero) begin
                        n_step = ST_SETUP_SIZE;
                    end
                end
            end
            default: n_step = ST_IDLE;
        endcase
    end

    assign o_uword = uw;

endmodule

// ===== rtl/core/lre_dp.sv =====
module lre_dp import lre_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 8,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dop                  i_dop,
    input  logic [SIZE_BITS-1:0]  i_line_width,
    input  logic [SIZE_BITS-1:0]  i_line_count,
    input  logic [STEP_BITS-1:0]  i_step_mag,
    input  logic                  i_step_neg,
    input  logic [PIXEL_BITS-1:0] i_rdata,
    output t_loop_flags           o_loop,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [PIXEL_BITS-1:0] o_wr_data
);

    localparam int RW = PIXEL_BITS + FRAC_BITS;
    localparam int EW = ((RW > STEP_BITS) ? RW : STEP_BITS) + 1;
    localparam logic [12:0] MAX_W = 13'(MAX_WIDTH);
    localparam logic [12:0] MAX_H = 13'(MAX_HEIGHT);

    t_pass                r_pass;
    logic [SIZE_BITS-1:0] r_pos;
    logic [SIZE_BITS-1:0] r_line;
    logic [RW-1:0]        r_prev;
    logic [SIZE_BITS-1:0] r_w;
    logic [SIZE_BITS-1:0] r_h;
    logic [AW-1:0]        r_last_row;
    logic [AW-1:0]        r_base;
    logic [AW-1:0]        r_addr;

    logic [SIZE_BITS-1:0] n_w;
    logic [SIZE_BITS-1:0] n_h;
    logic                 is_col;
    logic [SIZE_BITS-1:0] line_len;
    logic [SIZE_BITS-1:0] line_num;
    logic [AW-1:0]        w_a;
    logic [AW-1:0]        next_addr;
    logic [AW-1:0]        pass_base;
    logic [EW-1:0]        pix_e;
    logic [EW-1:0]        prev_e;
    logic [EW-1:0]        step_e;
    logic [EW-1:0]        diff_e;
    logic [EW-1:0]        sum_e;
    logic [EW-1:0]        env_e;
    logic [RW-1:0]        env;

    // Clamp the configured size into 1..MAX.
    always_comb begin
        if (i_line_width == '0) begin
            n_w = SIZE_BITS'(1);
        end else if ({4'b0, i_line_width} > MAX_W) begin
            n_w = MAX_W[SIZE_BITS-1:0];
        end else begin
            n_w = i_line_width;
        end
        if (i_line_count == '0) begin
            n_h = SIZE_BITS'(1);
        end else if ({4'b0, i_line_count} > MAX_H) begin
            n_h = MAX_H[SIZE_BITS-1:0];
        end else begin
            n_h = i_line_count;
        end
    end

    assign is_col   = (r_pass == PS_COL_FWD) || (r_pass == PS_COL_REV);
    assign line_len = is_col ? r_h : r_w;
    assign line_num = is_col ? r_w : r_h;
    assign w_a      = AW'(r_w);

    always_comb begin
        case (r_pass) inside
            PS_ROW_FWD: next_addr = r_addr + AW'(1);
            PS_ROW_REV: next_addr = r_addr - AW'(1);
            PS_COL_FWD: next_addr = r_addr + w_a;
            default:    next_addr = r_addr - w_a;
        endcase
        case (r_pass) inside
            PS_ROW_FWD, PS_COL_FWD: pass_base = '0;
            PS_ROW_REV:             pass_base = w_a - AW'(1);
            default:                pass_base = r_last_row;
        endcase
    end

    // Envelope: decay (rise when i_step_neg) toward the pixel, clamp at the pixel.
    always_comb begin
        pix_e  = EW'(i_rdata) << FRAC_BITS;
        prev_e = EW'(r_prev);
        step_e = EW'(i_step_mag);
        diff_e = prev_e - step_e;
        sum_e  = prev_e + step_e;
        if (i_step_neg) begin
            env_e = (sum_e < pix_e) ? sum_e : pix_e;
        end else begin
            env_e = (prev_e > step_e && diff_e > pix_e) ? diff_e : pix_e;
        end
        env = RW'(env_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= PS_ROW_FWD;
            r_pos  <= '0;
            r_line <= '0;
            r_prev <= '0;
        end else begin
            unique case (i_dop)
                DO_SIZE:  r_pass <= PS_ROW_FWD;
                DO_PASS:  r_line <= '0;
                DO_LINE:  r_pos  <= '0;
                DO_FIRST: r_prev <= RW'(pix_e);
                DO_ADV:   r_pos  <= r_pos + SIZE_BITS'(1);
                DO_UPD:   r_prev <= env;
                DO_LEND:  r_line <= r_line + SIZE_BITS'(1);
                DO_PEND:  r_pass <= t_pass'(2'(r_pass) + 2'd1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_dop)
            DO_SIZE: begin
                r_w <= n_w;
                r_h <= n_h;
            end
            DO_LAST: r_last_row <= AW'((r_h - SIZE_BITS'(1)) * r_w);
            DO_PASS: r_base <= pass_base;
            DO_LINE: r_addr <= r_base;
            DO_ADV:  r_addr <= next_addr;
            DO_LEND: r_base <= r_base + (is_col ? AW'(1) : w_a);
            default: ;
        endcase
    end

    assign o_loop.skip_pass   = (line_len == SIZE_BITS'(1));
    assign o_loop.more_pix    = (r_pos != line_len - SIZE_BITS'(1));
    assign o_loop.more_lines  = (r_line != line_num - SIZE_BITS'(1));
    assign o_loop.more_passes = (r_pass != PS_COL_REV);

    assign o_rd_en   = (i_dop == DO_LINE) || (i_dop == DO_ADV);
    assign o_rd_addr = (i_dop == DO_LINE) ? r_base : next_addr;
    assign o_wr_en   = (i_dop == DO_UPD);
    assign o_wr_addr = r_addr;
    assign o_wr_data = PIXEL_BITS'(env >> FRAC_BITS);

endmodule

// ===== rtl/core/linear_roof_envelope.sv =====
// Linear roof envelope over one stored image plane. Write commands load pixels
// into the frame store (MAX_WIDTH*MAX_HEIGHT entries, contents undefined until
// written, no clearing pass), read commands return them, and a run command
// sweeps the loaded image in four passes: rows left to right, rows right to
// left, columns top to bottom, columns bottom to top; the row passes run only
// when the clamped width exceeds 1, the column passes only when the clamped
// height does. Along each line a running value with FRAC_BITS fraction bits
// decays by step_magnitude per pixel and is clamped at the pixel (maximum
// envelope; minimum envelope with rising step when step_negative is set), and
// each pixel is written back truncated. A run with a zero step is refused with
// status 1 and leaves the store untouched. Every command returns exactly one
// result transfer. A write, an unknown command or a refused run leaves the
// sequencer idle, so these stream at one per cycle while results are drained;
// a read passes through a wait step for the registered read of the frame
// store. A run is driven by a small microcoded sequencer; each pixel after the
// first of a line takes a read step and then an update step, and the frame
// store has a single read port and a single write port. The user must write
// the configuration registers only while the block is idle; the block itself
// does not enforce this.
module linear_roof_envelope import lre_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lre_in_if.sink                   i_in,
    lre_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers.
    logic [SIZE_BITS-1:0]      r_line_width;
    logic [SIZE_BITS-1:0]      r_line_count;
    logic [STEP_BITS-1:0]      r_step_mag;
    logic                      r_step_neg;

    // Result register: parts the command side from the result side.
    logic                      r_out_valid;
    logic [PIX_FIELD_BITS-1:0] r_read_value;
    logic                      r_status;
    logic                      out_load;
    logic [PIX_FIELD_BITS-1:0] n_read_value;
    logic                      n_status;

    logic                      r_rd_ok;

    t_uword                    uw;
    t_loop_flags               loop_flags;
    t_host_req                 host_req;
    t_cmd                      cmd;
    logic                      accept;
    logic                      idx_ok;
    logic                      host_wr;
    logic                      host_rd;

    logic                      dp_rd_en;
    logic [AW-1:0]             dp_rd_addr;
    logic                      dp_wr_en;
    logic [AW-1:0]             dp_wr_addr;
    logic [PIXEL_BITS-1:0]     dp_wr_data;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [PIXEL_BITS-1:0]     mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [PIXEL_BITS-1:0]     mem_rdata;

    // Take commands only in the idle step and only when the result slot is
    // free or being drained in this cycle.
    assign i_in.ready = uw.host && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign cmd        = t_cmd'(i_in.cmd);
    assign idx_ok     = 32'(i_in.pixel_index) < 32'(DEPTH);

    assign host_req.accept    = accept;
    assign host_req.cmd       = cmd;
    assign host_req.step_zero = (r_step_mag == '0);

    assign host_wr = accept && (cmd == CMD_WRITE) && idx_ok;
    assign host_rd = accept && (cmd == CMD_READ) && idx_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= SIZE_BITS'(256);
            r_line_count <= SIZE_BITS'(256);
            r_step_mag   <= STEP_BITS'(256);
            r_step_neg   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CR_LINE_WIDTH:    r_line_width <= i_cfg_data[SIZE_BITS-1:0];
                CR_LINE_COUNT:    r_line_count <= i_cfg_data[SIZE_BITS-1:0];
                CR_STEP_MAG:      r_step_mag   <= i_cfg_data[STEP_BITS-1:0];
                CR_STEP_NEGATIVE: r_step_neg   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    lre_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_loop  (loop_flags),
        .i_host  (host_req),
        .o_uword (uw)
    );

    lre_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dop        (uw.dop),
        .i_line_width (r_line_width),
        .i_line_count (r_line_count),
        .i_step_mag   (r_step_mag),
        .i_step_neg   (r_step_neg),
        .i_rdata      (mem_rdata),
        .o_loop       (loop_flags),
        .o_rd_en      (dp_rd_en),
        .o_rd_addr    (dp_rd_addr),
        .o_wr_en      (dp_wr_en),
        .o_wr_addr    (dp_wr_addr),
        .o_wr_data    (dp_wr_data)
    );

    // Host accesses happen only in the idle step, run accesses never do, so
    // a plain select shares the frame store ports.
    assign mem_we    = host_wr || dp_wr_en;
    assign mem_waddr = host_wr ? AW'(i_in.pixel_index) : dp_wr_addr;
    assign mem_wdata = host_wr ? PIXEL_BITS'(i_in.pixel_value) : dp_wr_data;
    assign mem_re    = host_rd || dp_rd_en;
    assign mem_raddr = host_rd ? AW'(i_in.pixel_index) : dp_rd_addr;

    lre_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Hold whether the pending read hit the store; a miss answers zero.
    always_ff @(posedge i_clk) begin
        if (accept && cmd == CMD_READ) begin
            r_rd_ok <= idx_ok;
        end
    end

    always_comb begin
        out_load     = 1'b0;
        n_read_value = '0;
        n_status     = 1'b0;
        unique case (uw.oop)
            OO_READ: begin
                out_load     = 1'b1;
                n_read_value = r_rd_ok ? PIX_FIELD_BITS'(mem_rdata) : '0;
            end
            OO_RUN: out_load = 1'b1;
            default: begin
                // Reads and accepted runs answer later from their own steps.
                if (accept && cmd != CMD_READ) begin
                    if (cmd == CMD_RUN) begin
                        out_load = host_req.step_zero;
                        n_status = 1'b1;
                    end else begin
                        out_load = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_read_value;
    assign o_out.status     = r_status;

endmodule

// ===== rtl/core/lre_checker.sv =====
`include "assert_macros.svh"

module lre_checker import lre_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic [CMD_BITS-1:0]       i_in_cmd,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [PIX_FIELD_BITS-1:0] i_out_read_value,
    input logic                      i_out_status
);

    // Reset empties the result slot.
    `AST_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)
    // A command is taken only when its result can find room.
    `AST_HOLDS(a_room, i_clk, i_rst_n, i_in_ready && i_out_valid |-> i_out_ready)
    // A write answers in the very next cycle.
    `AST_HOLDS(a_wr_lat, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_cmd == CMD_WRITE |=> i_out_valid)
    // A read holds off the next command while the store answers.
    `AST_HOLDS(a_rd_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_cmd == CMD_READ |=> !i_in_ready)
    // A refusal never carries pixel data.
    `AST_HOLDS(a_refuse, i_clk, i_rst_n, i_out_valid && i_out_status |-> i_out_read_value == '0)

endmodule

bind linear_roof_envelope lre_checker u_lre_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_cmd         (i_in.cmd),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_read_value (o_out.read_value),
    .i_out_status     (o_out.status)
);

// ===== sim/linear_roof_envelope_tb.sv =====
`timescale 1ns / 1ps

module linear_roof_envelope_tb;
    import lre_pkg::*;

    localparam int FRAME_W_MAX  = 256;
    localparam int FRAME_H_MAX  = 256;
    localparam int FRAME_DEPTH  = FRAME_W_MAX * FRAME_H_MAX;
    localparam int FRAC         = 8;
    localparam int RANDOM_ITEMS = 1750;
    // Bound on the whole simulation, counted by the watchdog from the start.
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef struct {
        bit [PIX_FIELD_BITS-1:0] read_value;
        bit                      status;
    } t_env_result;

    // Scoreboard: a shadow frame store and register copy that predict the
    // result of every accepted command, plus the queue of results still owed.
    class t_envelope_scoreboard;
        bit [PIX_FIELD_BITS-1:0] frame [FRAME_DEPTH];
        bit                      written [FRAME_DEPTH];
        int                      written_list [$];
        t_env_result             pending [$];
        bit [SIZE_BITS-1:0]      width_raw = 9'd256;
        bit [SIZE_BITS-1:0]      count_raw = 9'd256;
        bit [STEP_BITS-1:0]      step_mag  = 24'd256;
        bit                      step_neg  = 1'b0;
        int                      mismatches = 0;
        int                      checked    = 0;

        function void set_reg(t_cfg_reg r, bit [CFG_DATA_BITS-1:0] d);
            case (r)
                CR_LINE_WIDTH:    width_raw = d[SIZE_BITS-1:0];
                CR_LINE_COUNT:    count_raw = d[SIZE_BITS-1:0];
                CR_STEP_MAG:      step_mag  = d[STEP_BITS-1:0];
                CR_STEP_NEGATIVE: step_neg  = d[0];
                default: ;
            endcase
        endfunction

        // Sizes as the run sees them, saturated into the frame limits.
        function int eff_width();
            if (width_raw == 0) return 1;
            if (width_raw > FRAME_W_MAX) return FRAME_W_MAX;
            return int'(width_raw);
        endfunction

        function int eff_height();
            if (count_raw == 0) return 1;
            if (count_raw > FRAME_H_MAX) return FRAME_H_MAX;
            return int'(count_raw);
        endfunction

        function int region_size();
            return eff_width() * eff_height();
        endfunction

        // A run may only touch pixels that were loaded.
        function bit region_loaded();
            for (int i = 0; i < region_size(); i++)
                if (!written[i]) return 1'b0;
            return 1'b1;
        endfunction

        function int loaded_index();
            return written_list[$urandom_range(written_list.size() - 1)];
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // One line of the envelope: seed with the first pixel, then decay and
        // clamp against each following pixel, writing back the integer part.
        function void sweep_line(int base, int stride, int n);
            longint unsigned run_val;
            longint unsigned pix;
            longint unsigned grown;
            int pos;
            pos = base;
            run_val = 64'(frame[pos]) << FRAC;
            for (int i = 1; i < n; i++) begin
                pos += stride;
                pix = 64'(frame[pos]) << FRAC;
                if (!step_neg) begin
                    if (run_val > step_mag && run_val - step_mag > pix)
                        run_val = run_val - step_mag;
                    else
                        run_val = pix;
                end else begin
                    grown = run_val + step_mag;
                    run_val = (grown < pix) ? grown : pix;
                end
                frame[pos] = PIX_FIELD_BITS'(run_val >> FRAC);
            end
        endfunction

        function void envelope_passes();
            int w;
            int h;
            w = eff_width();
            h = eff_height();
            if (w > 1) begin
                for (int k = 0; k < h; k++) sweep_line(k * w, 1, w);
                for (int k = 0; k < h; k++) sweep_line(k * w + w - 1, -1, w);
            end
            if (h > 1) begin
                for (int k = 0; k < w; k++) sweep_line(k, w, h);
                for (int k = 0; k < w; k++) sweep_line((h - 1) * w + k, -w, h);
            end
        endfunction

        // Every index fits the store at this frame size, so no range check.
        function void note_command(t_cmd op, bit [IDX_BITS-1:0] idx,
                                   bit [PIX_FIELD_BITS-1:0] val);
            t_env_result res;
            res.read_value = '0;
            res.status     = 1'b0;
            case (op)
                CMD_WRITE: begin
                    frame[idx] = val;
                    if (!written[idx]) begin
                        written[idx] = 1'b1;
                        written_list.insert(written_list.size(), int'(idx));
                    end
                end
                CMD_RUN: begin
                    if (step_mag == 0) res.status = 1'b1;
                    else envelope_passes();
                end
                CMD_READ: res.read_value = frame[idx];
                default: ;
            endcase
            pending.insert(pending.size(), res);
        endfunction

        function void check_result(logic [PIX_FIELD_BITS-1:0] rd, logic st);
            t_env_result exp_res;
            checked++;
            if (pending.size() == 0) begin
                $error("result transfer with no command outstanding: %s %0h status %0b",
                       "read_value", rd, st);
                mismatches++;
                return;
            end
            exp_res = pending[0];
            pending.delete(0);
            if (rd !== exp_res.read_value) begin
                $error("read_value mismatch: expected %0h, actual %0h",
                       exp_res.read_value, rd);
                mismatches++;
            end
            if (st !== exp_res.status) begin
                $error("status mismatch: expected %0b, actual %0b", exp_res.status, st);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    lre_in_if  in_ch ();
    lre_out_if out_ch ();

    linear_roof_envelope dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_envelope_scoreboard sb = new();

    // Idle odds (percent) for the command source and the result sink; each
    // random phase picks new ones, zero giving back-to-back traffic.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int cycle_count   = 0;
    int issued        = 0;
    int n_writes      = 0;
    int n_reads       = 0;
    int n_runs        = 0;
    int n_refused     = 0;
    int n_nops        = 0;
    int n_phases      = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result sink: check each transfer, then decide whether to stall.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.read_value, out_ch.status);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                stall = idle_len(sink_idle_pct);
            end
        end
    end

    // Offer one command, hold it until the transfer, then predict its result.
    // Valid is only lowered when a gap follows, so it never toggles in a step.
    task automatic send_command(input t_cmd op, input logic [IDX_BITS-1:0] idx,
                                input logic [PIX_FIELD_BITS-1:0] val);
        int gap;
        gap = idle_len(src_idle_pct);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= op;
        in_ch.pixel_index <= idx;
        in_ch.pixel_value <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_command(op, idx, val);
        case (op)
            CMD_WRITE: n_writes++;
            CMD_READ:  n_reads++;
            CMD_RUN: begin
                n_runs++;
                if (sb.step_mag == 0) n_refused++;
            end
            default:   n_nops++;
        endcase
        if (op != CMD_NOP) issued++;
    endtask

    // Stop sending and hold off until every owed result has come back; the
    // extra wait lets the block settle before any register write.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers back to back, only while the block is idle.
    task automatic program_regs(input int w_raw, input int h_raw,
                                input int step, input bit neg);
        t_cfg_reg                 regs [4];
        logic [CFG_DATA_BITS-1:0] vals [4];
        regs = '{CR_LINE_WIDTH, CR_LINE_COUNT, CR_STEP_MAG, CR_STEP_NEGATIVE};
        vals = '{CFG_DATA_BITS'(w_raw), CFG_DATA_BITS'(h_raw),
                 CFG_DATA_BITS'(step), CFG_DATA_BITS'(neg)};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            sb.set_reg(regs[r], vals[r]);
        end
        i_cfg_we <= 1'b0;
        n_phases++;
    endtask

    function automatic logic [PIX_FIELD_BITS-1:0] pick_pixel(int style, int base);
        case (style)
            0: return PIX_FIELD_BITS'($urandom_range(0, 65535));
            // Clustered values keep neighbors within a few steps of each
            // other, so both the decay and the clamp get exercised.
            1: return PIX_FIELD_BITS'(base + $urandom_range(0, 31));
            default: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return '1;
                    default: return PIX_FIELD_BITS'($urandom_range(0, 65535));
                endcase
            end
        endcase
    endfunction

    task automatic random_phase(input int phase_no);
        int w_raw;
        int h_raw;
        int step;
        int pick;
        int style;
        int base;
        int span;
        int n_items;
        bit neg;

        // Size: the first few phases force the saturation extremes, later
        // ones are mostly small frames so the runs stay short.
        pick = $urandom_range(99);
        case (phase_no)
            0: begin w_raw = 256; h_raw = 1; end
            1: begin w_raw = 1;   h_raw = 256; end
            2: begin w_raw = 511; h_raw = 0; end
            3: begin w_raw = 0;   h_raw = 511; end
            default: begin
                if (pick < 92) begin
                    w_raw = $urandom_range(1, 12);
                    h_raw = $urandom_range(1, 12);
                end else if (pick < 94) begin
                    w_raw = $urandom_range(256, 511);
                    h_raw = $urandom_range(0, 1);
                end else if (pick < 96) begin
                    w_raw = $urandom_range(0, 1);
                    h_raw = $urandom_range(256, 511);
                end else begin
                    w_raw = $urandom_range(0, 20);
                    h_raw = $urandom_range(0, 20);
                end
            end
        endcase

        pick = $urandom_range(99);
        if (pick < 10)      step = 0;
        else if (pick < 18) step = 24'hFFFFFF;
        else if (pick < 30) step = $urandom_range(0, 24'hFFFFFF);
        else                step = $urandom_range(1, 24'h800);
        neg = 1'($urandom_range(1));

        case ($urandom_range(3))
            0:       src_idle_pct = 0;
            1:       src_idle_pct = 10;
            2:       src_idle_pct = 30;
            default: src_idle_pct = 60;
        endcase
        case ($urandom_range(3))
            0:       sink_idle_pct = 0;
            1:       sink_idle_pct = 10;
            2:       sink_idle_pct = 30;
            default: sink_idle_pct = 60;
        endcase

        program_regs(w_raw, h_raw, step, neg);
        span = sb.region_size();

        if (phase_no < 4 || $urandom_range(99) < 80) begin
            // Load the whole frame, run the envelope, read parts of it back.
            style = $urandom_range(2);
            base  = $urandom_range(0, 65504);
            for (int i = 0; i < span; i++) begin
                send_command(CMD_WRITE, IDX_BITS'(i), pick_pixel(style, base));
                if ($urandom_range(9) == 0)
                    send_command(CMD_READ, IDX_BITS'(sb.loaded_index()), '0);
            end
            send_command(CMD_RUN, IDX_BITS'($urandom), PIX_FIELD_BITS'($urandom));
            n_items = $urandom_range(1, (span < 8) ? span : 8);
            for (int i = 0; i < n_items; i++)
                send_command(CMD_READ, IDX_BITS'($urandom_range(0, span - 1)), '0);
            if ($urandom_range(9) < 3) begin
                send_command(CMD_RUN, IDX_BITS'($urandom), PIX_FIELD_BITS'($urandom));
                send_command(CMD_READ, IDX_BITS'($urandom_range(0, span - 1)), '0);
            end
        end else begin
            // Noise: scattered writes anywhere, reads of loaded pixels,
            // unknown commands, and runs only when the frame is loaded or the run is refused.
            n_items = $urandom_range(5, 30);
            for (int i = 0; i < n_items; i++) begin
                pick = $urandom_range(99);
                if (pick < 40 || sb.written_list.size() == 0)
                    send_command(CMD_WRITE, IDX_BITS'($urandom), PIX_FIELD_BITS'($urandom));
                else if (pick < 75)
                    send_command(CMD_READ, IDX_BITS'(sb.loaded_index()),
                                 PIX_FIELD_BITS'($urandom));
                else if (pick < 85)
                    send_command(CMD_NOP, IDX_BITS'($urandom), PIX_FIELD_BITS'($urandom));
                else if (sb.step_mag == 0 || sb.region_loaded())
                    send_command(CMD_RUN, IDX_BITS'($urandom), PIX_FIELD_BITS'($urandom));
                else
                    send_command(CMD_READ, IDX_BITS'(sb.loaded_index()), '0);
            end
        end
        drain_results();
    endtask

    initial begin
        int random_start;
        int phase_no;
        logic [PIX_FIELD_BITS-1:0] small_frame [6];

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CR_LINE_WIDTH;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_NOP;
        in_ch.pixel_index <= '0;
        in_ch.pixel_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: index and value extremes at reset settings; every bit of
        // both fields goes high and low across these four writes.
        send_command(CMD_WRITE, 16'h0000, 16'hFFFF);
        send_command(CMD_WRITE, 16'hFFFF, 16'h0000);
        send_command(CMD_WRITE, 16'h5555, 16'hAAAA);
        send_command(CMD_WRITE, 16'hAAAA, 16'h5555);
        send_command(CMD_READ, 16'hFFFF, 16'h0000);
        send_command(CMD_READ, 16'h0000, 16'hFFFF);
        send_command(CMD_READ, 16'hAAAA, 16'h0000);
        send_command(CMD_READ, 16'h5555, 16'h0000);
        // Unknown command: no effect, read_value and status both zero.
        send_command(CMD_NOP, 16'h1234, 16'hBEEF);
        drain_results();

        // Zero sizes saturate to a single pixel; a zero step refuses the run.
        program_regs(0, 0, 0, 1'b0);
        send_command(CMD_RUN, 16'h0000, 16'h0000);
        drain_results();

        // Full-scale step on a single pixel: not refused, nothing moves.
        program_regs(0, 0, 24'hFFFFFF, 1'b1);
        send_command(CMD_RUN, 16'h0000, 16'h0000);
        send_command(CMD_READ, 16'h0000, 16'h0000);
        drain_results();

        // Small 3x2 frame, maximum envelope then minimum envelope.
        small_frame = '{16'd100, 16'd0, 16'd0, 16'hFFFF, 16'd7, 16'd0};
        program_regs(3, 2, 24'h180, 1'b0);
        for (int i = 0; i < 6; i++)
            send_command(CMD_WRITE, IDX_BITS'(i), small_frame[i]);
        send_command(CMD_RUN, 16'h0000, 16'h0000);
        send_command(CMD_READ, 16'd0, 16'h0000);
        send_command(CMD_READ, 16'd5, 16'h0000);
        send_command(CMD_READ, 16'd3, 16'h0000);
        drain_results();
        program_regs(3, 2, 24'h180, 1'b1);
        send_command(CMD_RUN, 16'h0000, 16'h0000);
        send_command(CMD_READ, 16'd2, 16'h0000);
        drain_results();

        // Random phases: each reprograms the block, mostly loads and runs a
        // fresh frame, and ends with the source held off until all results
        // are back.
        random_start = issued;
        phase_no = 0;
        while (issued - random_start < RANDOM_ITEMS) begin
            random_phase(phase_no);
            phase_no++;
        end

        drain_results();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d pixel writes, %0d reads, %0d envelope runs (%0d refused)",
                 n_writes, n_reads, n_runs, n_refused);
        $display("and %0d unknown commands over %0d register settings; %0d checked, %0d bad",
                 n_nops, n_phases, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== linear_roof_envelope.f =====
+incdir+rtl/core
rtl/core/lre_pkg.sv
rtl/core/lre_in_if.sv
rtl/core/lre_out_if.sv
rtl/core/lre_ram.sv
rtl/core/lre_seq.sv
rtl/core/lre_dp.sv
rtl/core/linear_roof_envelope.sv
rtl/core/lre_checker.sv
sim/linear_roof_envelope_tb.sv
